// ===== hw/rtl/b64e_pkg.sv =====
// shared types, constants and the character map of the base64 encoder
package b64e_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] PadChar = 8'h3D;
   localparam logic [5:0] SextetMask = 6'h3F;

   // padding codes carried with each group
   localparam logic [1:0] PadNone = 2'd0;
   localparam logic [1:0] PadOne = 2'd1;
   localparam logic [1:0] PadTwo = 2'd2;

   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  pad;
      logic        last;
   } b64e_group_type;

   typedef struct packed {
      logic           valid;
      b64e_group_type entry;
   } b64e_push_type;

   typedef struct packed {
      logic           valid;
      b64e_group_type entry;
   } b64e_head_type;

   // standard alphabet: A-Z a-z 0-9 + /
   function automatic logic [7:0] sextet_to_char(input logic [5:0] sextet);
      logic [7:0] code;
      code = {2'b00, sextet & SextetMask};
      if (code < 8'd26) begin
         return 8'h41 + code;
      end else if (code < 8'd52) begin
         return 8'h61 + (code - 8'd26);
      end else if (code < 8'd62) begin
         return 8'h30 + (code - 8'd52);
      end else if (code == 8'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

// ===== hw/rtl/b64e_if.sv =====
// valid/ready channel interfaces for raw bytes and encoded characters
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
// front end: takes raw bytes, holds partial groups, pushes each group once it is complete or the message ends
module b64e_front import b64e_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    data_byte,
   input  logic          end_of_message,
   input  logic          queue_full,
   output b64e_push_type push
);

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        accept;
   logic        store_only;

   assign in_ready = !queue_full;
   assign accept = in_valid && in_ready;
   assign store_only = (held_count_ff != 2'd2) && !end_of_message;

   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      push.valid = accept && !store_only;
      push.entry.last = end_of_message;
      push.entry.group = {data_byte, 16'h0000};
      push.entry.pad = PadTwo;
      unique case (held_count_ff)
         2'd0: begin
            push.entry.group = {data_byte, 16'h0000};
            push.entry.pad = PadTwo;
         end
         2'd1: begin
            push.entry.group = {held_bytes_ff[15:8], data_byte, 8'h00};
            push.entry.pad = PadOne;
         end
         default: begin
            push.entry.group = {held_bytes_ff, data_byte};
            push.entry.pad = PadNone;
         end
      endcase
      if (accept) begin
         if (store_only) begin
            if (held_count_ff == 2'd0) begin
               held_bytes_in = {data_byte, 8'h00};
            end else begin
               held_bytes_in = {held_bytes_ff[15:8], data_byte};
            end
            held_count_in = held_count_ff + 2'd1;
         end else begin
            held_bytes_in = 16'h0000;
            held_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= 16'h0000;
         held_count_ff <= 2'd0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// short group queue between front and back ends
module b64e_queue import b64e_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  b64e_push_type push,
   output logic          full,
   output b64e_head_type head,
   input  logic          pop
);

   b64e_group_type entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == QueueCountWidth'(QueueDepth));
   assign do_push = push.valid && !full;
   assign do_pop = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// back end: emits the four characters of the head group, one per cycle while the output is not stalled
module b64e_back import b64e_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  b64e_head_type head,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_char,
   output logic          last_char
);

   logic [1:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       advance;
   logic [5:0] sextet;

   assign out_valid = valid_ff;
   assign out_char = char_ff;
   assign last_char = last_ff;

   // output register free or draining this cycle
   assign advance = head.valid && (!valid_ff || out_ready);
   assign pop = advance && (index_ff == 2'd3);

   always_comb begin
      unique case (index_ff)
         2'd0: sextet = head.entry.group[23:18];
         2'd1: sextet = head.entry.group[17:12];
         2'd2: sextet = head.entry.group[11:6];
         default: sextet = head.entry.group[5:0];
      endcase
   end

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff && !out_ready;
      char_in = char_ff;
      last_in = last_ff;
      if (advance) begin
         index_in = index_ff + 2'd1;
         valid_in = 1'b1;
         char_in = sextet_to_char(sextet);
         if ((index_ff == 2'd3) && (head.entry.pad != PadNone)) begin
            char_in = PadChar;
         end
         if ((index_ff == 2'd2) && (head.entry.pad == PadTwo)) begin
            char_in = PadChar;
         end
         last_in = head.entry.last && (index_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// Streaming base64 encoder, standard alphabet with '=' padding.
//
// req_chan carries one raw byte per transaction with end_of_message set on
// the final byte of a message. rsp_chan carries one ASCII character per
// transaction; last_char marks the final character of a message.
// The front end keeps up to two pending bytes; the third byte of a group, or
// a byte with end_of_message, closes the group and pushes it into a
// two-entry queue. A group closed early is zero filled and its last one or
// two characters come out as '='.
// The back end reads the queue head and emits its four characters at one
// per cycle, unless the receiver stalls, through an output register. A
// closed group passes through the queue and then the output register
// before its first character appears. The front end keeps taking bytes
// while the back end emits; bytes that only fill a group are taken at one
// per cycle while the queue has room.
// Reset clears the pending bytes, empties the queue and clears the output valid.
// When the receiver holds rsp_chan.ready low, the current character holds,
// the queue fills, and req_chan.ready drops once both entries are taken.
module base64_stream_encoder import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   b64e_req_if.sink     req_chan,
   b64e_rsp_if.source   rsp_chan
);

   b64e_push_type push;
   b64e_head_type head;
   logic          queue_full;
   logic          pop;

   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .data_byte      (req_chan.data_byte),
      .end_of_message (req_chan.end_of_message),
      .queue_full     (queue_full),
      .push           (push)
   );

   b64e_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_char  (rsp_chan.out_char),
      .last_char (rsp_chan.last_char)
   );

endmodule

// ===== hw/rtl/b64e_checker.sv =====
// port-level checks on the encoder's character stream, bound to the top level
module b64e_checker import b64e_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);

   logic [1:0] pos_ff;
   logic       prev_pad_ff;
   logic       rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // position of the next character within its group of four
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         prev_pad_ff <= 1'b0;
      end else if (rsp_fire) begin
         pos_ff <= pos_ff + 2'd1;
         prev_pad_ff <= (rsp_out_char == PadChar);
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("character changed while stalled");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last_char |-> pos_ff == 2'd3)
      else $error("last character not at end of a group");

   a_pad_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (rsp_out_char == PadChar) |-> pos_ff == 2'd2 || pos_ff == 2'd3)
      else $error("padding in the first half of a group");

   a_pad_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (pos_ff == 2'd3) && prev_pad_ff |-> rsp_out_char == PadChar && rsp_last_char)
      else $error("double padding not closed by padding on the last character");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_char  (rsp_chan.out_char),
   .rsp_last_char (rsp_chan.last_char)
);
